// ===== sv/bf5r_pkg.sv =====
// ----------------------------------------------------------------------------
// bf5r_pkg: shared constants and types for the 5x5 box filter
// Register indexes, operation codes, field widths, reset values and the
// reciprocal used to divide window sums by the window area.
// ----------------------------------------------------------------------------
package bf5r_pkg;

  // Elaboration defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF  = 3;

  // Port field widths
  localparam int PIX_W        = 8;
  localparam int PIX_CH       = 3;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  // Register reset values
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COLOR_MODE   = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    MODE_GREY  = 1'b0,
    MODE_COLOR = 1'b1
  } color_mode_t;

  // Window geometry
  localparam int WIN_SIZE  = 5;
  localparam int AREA      = WIN_SIZE * WIN_SIZE;
  localparam int LINE_ROWS = WIN_SIZE - 1;

  // Sum widths: five pixels per column, five columns per window
  localparam int COL_SUM_W = PIX_W + 3;
  localparam int WIN_SUM_W = PIX_W + 5;

  // x / AREA == (x * RECIP) >> RECIP_SHIFT for every x below 2**WIN_SUM_W
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + AREA - 1) / AREA;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = WIN_SUM_W + RECIP_W;

  // Counter widths
  localparam int IN_ROW_W = HEIGHT_REG_W + 1;
  localparam int LEAD_W   = WIDTH_REG_W + 2;

  // Result queue ahead of the output port
  localparam int OUT_DEPTH = 8;

  // Per-item control that rides along with the pipeline
  typedef struct packed {
    logic last;  // final result of the frame
    logic lo1;   // one column to the left exists
    logic lo2;   // two columns to the left exist
    logic hi1;   // one column to the right exists
    logic hi2;   // two columns to the right exist
  } ctl_t;

endpackage

// ===== sv/bf5r_ram.sv =====
// ----------------------------------------------------------------------------
// bf5r_ram: generic single-clock RAM
// One write port, one read port with registered data. A read of the address
// being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module bf5r_ram #(
  parameter int WIDTH = bf5r_pkg::PIX_W,
  parameter int DEPTH = bf5r_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/box_filter_5x5_replicate_core.sv =====
// ----------------------------------------------------------------------------
// box_filter_5x5_replicate_core: streaming 5x5 mean filter, replicated borders
// Line store, column sums, horizontal window with edge clamping, divide by 25.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per clock, and each accepted beat
// gives at most one result: the truncated mean of the 5x5 neighbourhood of
// the pixel 2*W+2 beats earlier, with rows and columns clamped at the frame
// border. After the H*W pixels of a frame, send 2*W+2 more beats (flush or
// pixel, pixel data is dropped) to drain the last rows; frame_end marks the
// last result, after which the next pixel starts a new frame. A flush beat
// during pixel input is taken and ignored. The rate is one beat per clock,
// set by the line store, which does one read and one write-back per beat at
// the current column (the four previous rows of that column live in one
// word). Each kept beat passes stages B, C and D on its way to the output
// queue; an eight-entry queue decouples the output, and input is held off
// only when that queue and the results in flight would overflow it. No
// clearing pass is needed after reset. Writing a register restarts the frame.
// ----------------------------------------------------------------------------
module box_filter_5x5_replicate_core #(
  parameter int MAX_WIDTH = bf5r_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = bf5r_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bf5r_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bf5r_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic [bf5r_pkg::PIX_W-1:0]       pixel_ch0,
  input  logic [bf5r_pkg::PIX_W-1:0]       pixel_ch1,
  input  logic [bf5r_pkg::PIX_W-1:0]       pixel_ch2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bf5r_pkg::PIX_W-1:0]       mean_ch0,
  output logic [bf5r_pkg::PIX_W-1:0]       mean_ch1,
  output logic [bf5r_pkg::PIX_W-1:0]       mean_ch2,
  output logic                             frame_end
);

  localparam int PIX_W     = bf5r_pkg::PIX_W;
  localparam int PIX_CH    = bf5r_pkg::PIX_CH;
  localparam int WR_W      = bf5r_pkg::WIDTH_REG_W;
  localparam int HR_W      = bf5r_pkg::HEIGHT_REG_W;
  localparam int XW        = WR_W + 1;
  localparam int IN_ROW_W  = bf5r_pkg::IN_ROW_W;
  localparam int LEAD_W    = bf5r_pkg::LEAD_W;
  localparam int WIN_SIZE  = bf5r_pkg::WIN_SIZE;
  localparam int LINE_ROWS = bf5r_pkg::LINE_ROWS;
  localparam int COL_SUM_W = bf5r_pkg::COL_SUM_W;
  localparam int WIN_SUM_W = bf5r_pkg::WIN_SUM_W;
  localparam int PROD_W    = bf5r_pkg::PROD_W;
  localparam int SHIFT     = bf5r_pkg::RECIP_SHIFT;
  localparam int QDEPTH    = bf5r_pkg::OUT_DEPTH;
  localparam int PTR_W     = $clog2(QDEPTH);
  localparam int CNT_W     = PTR_W + 1;

  // Widest usable row: the register and the line store both bound it
  localparam int WREG_MAX = (1 << WR_W) - 1;
  localparam int WMAX     = (MAX_WIDTH < WREG_MAX) ? MAX_WIDTH : WREG_MAX;
  localparam int CW       = $clog2(WMAX);
  localparam int NCH      = (CHANNELS < PIX_CH) ? CHANNELS : PIX_CH;
  localparam int WORD_W   = LINE_ROWS * NCH * PIX_W;

  // --------------------------------------------------------------------------
  // Configuration and frame counters
  // --------------------------------------------------------------------------
  logic [WR_W-1:0]     image_width;
  logic [HR_W-1:0]     image_height;
  logic                color_mode;
  logic [WR_W-1:0]     eff_w;
  logic [HR_W-1:0]     eff_h;
  logic [LEAD_W-1:0]   delay;

  logic [IN_ROW_W-1:0] in_row;
  logic [CW-1:0]       in_col;
  logic [HR_W-1:0]     out_row;
  logic [CW-1:0]       out_col;
  logic [LEAD_W-1:0]   lead;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    used_next;

  logic                accept;
  logic                rx;
  logic                step;
  logic                res;
  logic                res_last;
  logic                in_col_last;
  logic                out_col_last;
  logic                restart;
  logic                pop;
  logic [XW-1:0]       oc_x;
  bf5r_pkg::ctl_t      ctl;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WR_W'(1);
    end else if (int'(image_width) > WMAX) begin
      eff_w = WR_W'(WMAX);
    end else begin
      eff_w = image_width;
    end
  end

  assign eff_h = (image_height == '0) ? HR_W'(1) : image_height;
  assign delay = LEAD_W'({eff_w, 1'b0}) + LEAD_W'(2);

  assign in_ready     = used < CNT_W'(QDEPTH);
  assign accept       = in_valid && in_ready;
  assign rx           = in_row < IN_ROW_W'(eff_h);
  // a flush while pixels are still due is taken and dropped
  assign step         = accept && !(rx && (operation == bf5r_pkg::OP_FLUSH));
  assign res          = step && (lead == delay);
  assign in_col_last  = WR_W'(in_col) == (eff_w - WR_W'(1));
  assign out_col_last = WR_W'(out_col) == (eff_w - WR_W'(1));
  assign res_last     = (out_row == (eff_h - HR_W'(1))) && out_col_last;
  assign pop          = out_valid && out_ready;

  assign restart = cfg_we && ((cfg_index == bf5r_pkg::REG_IMAGE_WIDTH) ||
                              (cfg_index == bf5r_pkg::REG_IMAGE_HEIGHT) ||
                              (cfg_index == bf5r_pkg::REG_COLOR_MODE));

  assign used_next = used + CNT_W'(res) - CNT_W'(pop);

  // Column clamp flags for the result position
  assign oc_x     = XW'(out_col);
  assign ctl.last = res_last;
  assign ctl.lo1  = out_col != '0;
  assign ctl.lo2  = out_col >= CW'(2);
  assign ctl.hi1  = (oc_x + XW'(1)) < XW'(eff_w);
  assign ctl.hi2  = (oc_x + XW'(2)) < XW'(eff_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WR_W'(bf5r_pkg::WIDTH_RESET);
      image_height <= HR_W'(bf5r_pkg::HEIGHT_RESET);
      color_mode   <= bf5r_pkg::MODE_GREY;
      in_row       <= '0;
      in_col       <= '0;
      out_row      <= '0;
      out_col      <= '0;
      lead         <= '0;
      used         <= '0;
    end else begin
      used <= used_next;
      if (cfg_we) begin
        case (cfg_index)
          bf5r_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[WR_W-1:0];
          bf5r_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[HR_W-1:0];
          bf5r_pkg::REG_COLOR_MODE:   color_mode   <= cfg_data[0];
          default: ;
        endcase
      end
      if (restart || (res && res_last)) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
        lead    <= '0;
      end else begin
        if (step) begin
          if (in_col_last) begin
            in_col <= '0;
            in_row <= in_row + IN_ROW_W'(1);
          end else begin
            in_col <= in_col + CW'(1);
          end
          if (lead != delay) begin
            lead <= lead + LEAD_W'(1);
          end
        end
        if (res) begin
          if (out_col_last) begin
            out_col <= '0;
            out_row <= out_row + HR_W'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: line store read-modify-write, column sums
  // --------------------------------------------------------------------------
  logic                 b_valid;
  logic                 b_res;
  logic                 b_rx;
  logic                 b_top;
  logic [CW-1:0]        b_x;
  logic [PIX_W-1:0]     b_pix [PIX_CH];
  bf5r_pkg::ctl_t       b_ctl;
  logic [PIX_W-1:0]     pix_in [PIX_CH];

  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    old_word;
  logic [WORD_W-1:0]    wr_word;
  logic                 fwd_valid;
  logic [CW-1:0]        fwd_addr;
  logic [WORD_W-1:0]    fwd_word;
  logic [COL_SUM_W-1:0] col_sum [PIX_CH];

  assign pix_in[0] = pixel_ch0;
  assign pix_in[1] = pixel_ch1;
  assign pix_in[2] = pixel_ch2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_res   <= 1'b0;
    end else begin
      b_valid <= step;
      b_res   <= res;
    end
  end

  always_ff @(posedge clk) begin
    b_rx  <= rx;
    b_top <= in_row == '0;
    b_x   <= in_col;
    b_ctl <= ctl;
    for (int ch = 0; ch < PIX_CH; ch++) begin
      b_pix[ch] <= pix_in[ch];
    end
  end

  bf5r_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WMAX)
  ) u_line_store (
    .clk  (clk),
    .we   (b_valid),
    .waddr(b_x),
    .wdata(wr_word),
    .re   (step),
    .raddr(in_col),
    .rdata(rd_word)
  );

  // A one-pixel-wide frame hits the same column every beat: take the word
  // written last cycle, which the read issued then did not see.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= b_x;
    fwd_word <= wr_word;
  end

  assign old_word = (fwd_valid && (fwd_addr == b_x)) ? fwd_word : rd_word;

  // Word layout: row j back (0 = newest), channel ch at (j*NCH + ch) * PIX_W
  for (genvar ch = 0; ch < PIX_CH; ch++) begin : g_col
    if (ch < NCH) begin : g_on
      logic [PIX_W-1:0] px_old [LINE_ROWS];
      logic [PIX_W-1:0] px_eff [LINE_ROWS];
      logic [PIX_W-1:0] px_new;

      always_comb begin
        for (int j = 0; j < LINE_ROWS; j++) begin
          px_old[j] = old_word[(j*NCH + ch)*PIX_W +: PIX_W];
        end
        // past the last row, repeat the bottom row
        px_new = b_rx ? b_pix[ch] : px_old[0];
        // first row of a frame: rows above it replicate it
        for (int j = 0; j < LINE_ROWS; j++) begin
          px_eff[j] = b_top ? px_new : px_old[j];
        end
      end

      assign wr_word[ch*PIX_W +: PIX_W] = px_new;
      for (genvar j = 1; j < LINE_ROWS; j++) begin : g_shift
        assign wr_word[(j*NCH + ch)*PIX_W +: PIX_W] = px_eff[j-1];
      end

      assign col_sum[ch] = COL_SUM_W'(px_new) + COL_SUM_W'(px_eff[0]) +
                           COL_SUM_W'(px_eff[1]) + COL_SUM_W'(px_eff[2]) +
                           COL_SUM_W'(px_eff[3]);
    end else begin : g_off
      assign col_sum[ch] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: column window with horizontal clamp
  // --------------------------------------------------------------------------
  logic [COL_SUM_W-1:0] col_sr [WIN_SIZE][PIX_CH];
  logic [COL_SUM_W-1:0] tap [WIN_SIZE][PIX_CH];
  logic [WIN_SUM_W-1:0] win_sum [PIX_CH];
  logic                 c_res;
  bf5r_pkg::ctl_t       c_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_res <= 1'b0;
    end else begin
      c_res <= b_valid && b_res;
    end
  end

  always_ff @(posedge clk) begin
    c_ctl <= b_ctl;
    if (b_valid) begin
      for (int ch = 0; ch < PIX_CH; ch++) begin
        col_sr[0][ch] <= col_sum[ch];
        for (int i = 1; i < WIN_SIZE; i++) begin
          col_sr[i][ch] <= col_sr[i-1][ch];
        end
      end
    end
  end

  // col_sr[2] holds the center column; out-of-frame columns take the edge one
  always_comb begin
    for (int ch = 0; ch < PIX_CH; ch++) begin
      tap[0][ch] = c_ctl.lo2 ? col_sr[4][ch] : (c_ctl.lo1 ? col_sr[3][ch] : col_sr[2][ch]);
      tap[1][ch] = c_ctl.lo1 ? col_sr[3][ch] : col_sr[2][ch];
      tap[2][ch] = col_sr[2][ch];
      tap[3][ch] = c_ctl.hi1 ? col_sr[1][ch] : col_sr[2][ch];
      tap[4][ch] = c_ctl.hi2 ? col_sr[0][ch] : (c_ctl.hi1 ? col_sr[1][ch] : col_sr[2][ch]);
      win_sum[ch] = WIN_SUM_W'(tap[0][ch]) + WIN_SUM_W'(tap[1][ch]) +
                    WIN_SUM_W'(tap[2][ch]) + WIN_SUM_W'(tap[3][ch]) +
                    WIN_SUM_W'(tap[4][ch]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: divide by the area, queue the result
  // --------------------------------------------------------------------------
  logic                 d_res;
  logic                 d_last;
  logic [WIN_SUM_W-1:0] d_sum [PIX_CH];
  logic [PROD_W-1:0]    prod [PIX_CH];
  logic [PIX_W-1:0]     mean_d [PIX_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_res <= 1'b0;
    end else begin
      d_res <= c_res;
    end
  end

  always_ff @(posedge clk) begin
    d_last <= c_ctl.last;
    for (int ch = 0; ch < PIX_CH; ch++) begin
      d_sum[ch] <= win_sum[ch];
    end
  end

  always_comb begin
    for (int ch = 0; ch < PIX_CH; ch++) begin
      prod[ch] = PROD_W'(d_sum[ch]) * PROD_W'(bf5r_pkg::RECIP);
      // grey mode keeps channel 0 only
      if ((ch == 0) || (color_mode == bf5r_pkg::MODE_COLOR)) begin
        mean_d[ch] = prod[ch][SHIFT +: PIX_W];
      end else begin
        mean_d[ch] = '0;
      end
    end
  end

  logic [PIX_W-1:0] q_mean [QDEPTH][PIX_CH];
  logic             q_last [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fifo_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (d_res) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + CNT_W'(d_res) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (d_res) begin
      q_last[wr_ptr] <= d_last;
      for (int ch = 0; ch < PIX_CH; ch++) begin
        q_mean[wr_ptr][ch] <= mean_d[ch];
      end
    end
  end

  assign out_valid = fifo_cnt != '0;
  assign mean_ch0  = q_mean[rd_ptr][0];
  assign mean_ch1  = q_mean[rd_ptr][1];
  assign mean_ch2  = q_mean[rd_ptr][2];
  assign frame_end = q_last[rd_ptr];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(QDEPTH))
    else $error("result credit count exceeds the output queue depth");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= used)
    else $error("output queue holds more results than were granted");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    d_res |-> ((fifo_cnt < CNT_W'(QDEPTH)) || pop))
    else $error("result pushed into a full output queue");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (res && res_last) |=> ((in_row == '0) && (out_row == '0) && (lead == '0)))
    else $error("counters not cleared after the last result of a frame");

endmodule

// ===== sim/bf5r_mean_checker.sv =====
// ----------------------------------------------------------------------------
// bf5r_mean_checker: scoreboard for the 5x5 replicated-border mean filter
// Watches the register port and both streams, keeps its own copy of the
// frame counters and line ring, predicts every mean and compares each
// output beat against the oldest prediction in order.
// ----------------------------------------------------------------------------
module bf5r_mean_checker #(
  parameter int MAX_WIDTH = bf5r_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = bf5r_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bf5r_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bf5r_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             operation,
  input  logic [bf5r_pkg::PIX_W-1:0]       pixel_ch0,
  input  logic [bf5r_pkg::PIX_W-1:0]       pixel_ch1,
  input  logic [bf5r_pkg::PIX_W-1:0]       pixel_ch2,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [bf5r_pkg::PIX_W-1:0]       mean_ch0,
  input  logic [bf5r_pkg::PIX_W-1:0]       mean_ch1,
  input  logic [bf5r_pkg::PIX_W-1:0]       mean_ch2,
  input  logic                             frame_end,
  output int                               fail_count,
  output int                               means_waiting,
  output int                               means_checked,
  output int                               frames_closed
);
  timeunit 1ns;
  timeprecision 1ps;
  import bf5r_pkg::*;

  localparam int RING_ROWS = 8;
  localparam int HALF_WIN  = WIN_SIZE / 2;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [PIX_W-1:0] ch2;
    logic [PIX_W-1:0] ch1;
    logic [PIX_W-1:0] ch0;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0] m0;
    logic [PIX_W-1:0] m1;
    logic [PIX_W-1:0] m2;
    logic             last;
  } mean_t;

  rgb_t                    line_ring [RING_ROWS*MAX_WIDTH];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  color_mode_t             mode;
  int unsigned             wr_row, wr_col, rd_row, rd_col, beats_in_frame;
  mean_t                   pending_means [$];
  int                      fails, checked, frames;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int unsigned clamp_idx(input int v, input int unsigned n);
    if (v < 0) return 0;
    if (v >= int'(n)) return n - 1;
    return v;
  endfunction

  function automatic void restart_frame();
    wr_row = 0;
    wr_col = 0;
    rd_row = 0;
    rd_col = 0;
    beats_in_frame = 0;
  endfunction

  // Advance the frame by one accepted beat; return 1 with the mean it releases.
  function automatic bit filter_beat(input op_t op, input rgb_t px, output mean_t res);
    int unsigned w, h, lag, rr, cc, sum0, sum1, sum2;
    int          dr, dc;
    rgb_t        p;
    w    = eff_width();
    h    = eff_height();
    lag  = 2 * w + 2;
    res  = '0;
    sum0 = 0;
    sum1 = 0;
    sum2 = 0;
    if (wr_row < h) begin
      // drop flush beats while the frame is still arriving
      if (op == OP_FLUSH) return 1'b0;
      line_ring[(wr_row % RING_ROWS) * MAX_WIDTH + wr_col] = px;
      wr_col++;
      if (wr_col >= w) begin
        wr_col = 0;
        wr_row++;
      end
    end
    beats_in_frame++;
    if (beats_in_frame <= lag) return 1'b0;
    for (dr = -HALF_WIN; dr <= HALF_WIN; dr++) begin
      rr = clamp_idx(int'(rd_row) + dr, h);
      for (dc = -HALF_WIN; dc <= HALF_WIN; dc++) begin
        cc = clamp_idx(int'(rd_col) + dc, w);
        p = line_ring[(rr % RING_ROWS) * MAX_WIDTH + cc];
        sum0 += p.ch0;
        sum1 += p.ch1;
        sum2 += p.ch2;
      end
    end
    res.m0 = (CHANNELS > 0) ? PIX_W'(sum0 / AREA) : '0;
    res.m1 = (mode == MODE_COLOR && CHANNELS > 1) ? PIX_W'(sum1 / AREA) : '0;
    res.m2 = (mode == MODE_COLOR && CHANNELS > 2) ? PIX_W'(sum2 / AREA) : '0;
    res.last = (rd_row == h - 1) && (rd_col == w - 1);
    if (res.last) begin
      restart_frame();
      frames++;
    end else begin
      rd_col++;
      if (rd_col >= w) begin
        rd_col = 0;
        rd_row++;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    mean_t want, got;
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mode       = MODE_GREY;
      restart_frame();
      pending_means.delete();
      fails   = 0;
      checked = 0;
      frames  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[WIDTH_REG_W-1:0];
            restart_frame();
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[HEIGHT_REG_W-1:0];
            restart_frame();
          end
          REG_COLOR_MODE: begin
            mode = color_mode_t'(cfg_data[0]);
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (filter_beat(op_t'(operation), '{ch2: pixel_ch2, ch1: pixel_ch1, ch0: pixel_ch0},
                        want))
          pending_means.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{m0: mean_ch0, m1: mean_ch1, m2: mean_ch2, last: frame_end};
        if (pending_means.size() == 0) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("%0t: result beat with no pending mean: m0=%0d m1=%0d m2=%0d end=%0b",
                     $realtime, got.m0, got.m1, got.m2, got.last);
        end else begin
          want = pending_means.pop_front();
          checked++;
          if (got.m0 !== want.m0 || got.m1 !== want.m1 || got.m2 !== want.m2 ||
              got.last !== want.last) begin
            fails++;
            if (fails <= MAX_SHOWN)
              $display({"%0t: mean #%0d mismatch: expected m0=%0d m1=%0d m2=%0d end=%0b,",
                        " got m0=%0d m1=%0d m2=%0d end=%0b"},
                       $realtime, checked, want.m0, want.m1, want.m2, want.last,
                       got.m0, got.m1, got.m2, got.last);
          end
        end
      end
    end
    fail_count    <= fails;
    means_waiting <= pending_means.size();
    means_checked <= checked;
    frames_closed <= frames;
  end

endmodule

// ===== sim/box_filter_5x5_replicate_core_tb.sv =====
// ----------------------------------------------------------------------------
// box_filter_5x5_replicate_core_tb: stream test of the 5x5 mean filter
// Programs frame geometry and colour mode between frames, streams random
// pixels with stray flush beats, drains most frames, and lets the checker
// score every mean while both handshakes stall at random.
// ----------------------------------------------------------------------------
module box_filter_5x5_replicate_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bf5r_pkg::*;

  localparam int TARGET_BEATS   = 950;
  localparam int MAX_GAP        = 16;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_SLACK    = 32;
  localparam int WATCHDOG_LIMIT = 2000;

  // index past the last register, must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   operation = OP_PIXEL;
  logic [PIX_W-1:0]       pixel_ch0 = '0;
  logic [PIX_W-1:0]       pixel_ch1 = '0;
  logic [PIX_W-1:0]       pixel_ch2 = '0;
  logic                   out_ready = 1'b0;
  logic                   in_ready, out_valid, frame_end;
  logic [PIX_W-1:0]       mean_ch0, mean_ch1, mean_ch2;

  int fail_count, means_waiting, means_checked, frames_closed;
  int beats_sent = 0;
  int cur_w = 1, cur_h = 1;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  box_filter_5x5_replicate_core u_top (.*);

  bf5r_mean_checker u_chk (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send_beat(input op_t op, input logic [PIX_W-1:0] c0, c1, c2);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    pixel_ch0 <= c0;
    pixel_ch1 <= c1;
    pixel_ch2 <= c2;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input op_t op);
    send_beat(op, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
              PIX_W'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every pending mean is out and the pipe is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (means_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit hold);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (!hold) cfg_we <= 1'b0;
  endtask

  // Unused upper data bits carry noise; the block keeps only the register width.
  task automatic program_regs(input int w, input int h, input color_mode_t m);
    logic [CFG_DATA_W-1:0] wdata, mdata;
    wdata = CFG_DATA_W'(w) | (CFG_DATA_W'($urandom) << WIDTH_REG_W);
    mdata = (CFG_DATA_W'($urandom) << 1) | CFG_DATA_W'(m);
    cfg_write(REG_IMAGE_WIDTH, wdata, 1'b1);
    cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h), 1'b1);
    cfg_write(REG_COLOR_MODE, mdata, 1'b0);
    cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
    cur_h = (h == 0) ? 1 : h;
  endtask

  // Pixels with stray flushes mixed in, then optionally the 2W+2 drain beats.
  task automatic stream_frame(input int pixels, input int noise_pct, input bit drain);
    int n;
    for (n = 0; n < pixels; n++) begin
      if ($urandom_range(0, 99) < noise_pct) send_random(OP_FLUSH);
      send_random(OP_PIXEL);
      beats_sent++;
    end
    if (drain) begin
      for (n = 0; n < 2 * cur_w + 2; n++) begin
        // pixel data sent during the drain is dropped by the block
        send_random($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL);
        beats_sent++;
      end
    end
  endtask

  initial begin : result_sink
    int stall, taken;
    taken = 0;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Stream stalled for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    bit need_cfg;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // One-pixel frame from zero width and height; flush around the drain is dropped.
    tx_calm = 1'b1;
    program_regs(0, 0, MODE_COLOR);
    send_beat(OP_FLUSH, '1, '1, '1);
    send_beat(OP_PIXEL, '1, '1, '1);
    send_beat(OP_FLUSH, '0, '0, '0);
    send_beat(OP_PIXEL, '0, '0, '0);
    send_beat(OP_FLUSH, '1, '0, '1);
    send_beat(OP_FLUSH, '0, '1, '0);
    send_beat(OP_FLUSH, '1, '1, '1);
    beats_sent += 5;
    settle();

    // 2x2 grey frame; a write to an unmapped index mid-frame must not restart it.
    tx_calm = 1'b0;
    program_regs(2, 2, MODE_GREY);
    send_beat(OP_PIXEL, '1, '0, '1);
    send_beat(OP_PIXEL, '0, '1, '0);
    settle();
    cfg_write(REG_UNMAPPED, '1, 1'b0);
    send_beat(OP_PIXEL, '1, '1, '1);
    send_beat(OP_PIXEL, '0, '0, '0);
    beats_sent += 4;
    stream_frame(0, 0, 1'b1);
    settle();

    // Tallest frame, abandoned after a few results by the next register write.
    program_regs(4, 16'hFFFF, MODE_COLOR);
    stream_frame(12, 0, 1'b0);

    need_cfg = 1'b1;
    while (beats_sent < TARGET_BEATS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      if (need_cfg || $urandom_range(0, 99) < 60) begin
        settle();
        program_regs(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12),
                     ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8),
                     color_mode_t'($urandom_range(0, 1)));
      end
      need_cfg = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        // cut the frame short; the next write restarts it
        stream_frame($urandom_range(1, cur_w * cur_h), 5, 1'b0);
        need_cfg = 1'b1;
      end else begin
        stream_frame(cur_w * cur_h, 5, 1'b1);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) send_random(OP_FLUSH);
      end
    end

    // Widest line, from an out-of-range width register.
    settle();
    program_regs(2047, 1, color_mode_t'($urandom_range(0, 1)));
    stream_frame(MAX_WIDTH_DEF, 2, 1'b1);

    in_valid <= 1'b0;
    do @(posedge clk); while (means_waiting != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
    $display("Streamed %0d beats: %0d means scored over %0d full frames,",
             beats_sent, means_checked, frames_closed);
    $display("grey and colour, widths 1 to %0d, heights 1 to 65535.", MAX_WIDTH_DEF);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
